// ----- sv/dte_pkg.sv -----
package dte_pkg;

   localparam int NumDigits = 8;
   localparam int NumHeld   = NumDigits - 1;
   localparam int CodeWidth = 27;

   localparam logic [3:0] TokenLen = 4'd11;
   localparam logic [3:0] PosLast  = 4'd10;
   localparam logic [3:0] PosD     = 4'd0;
   localparam logic [3:0] PosM     = 4'd3;
   localparam logic [3:0] PosY     = 4'd6;

   localparam logic [7:0] CharD    = 8'h64;
   localparam logic [7:0] CharM    = 8'h6d;
   localparam logic [7:0] CharY    = 8'h79;
   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharNine = 8'h39;

   localparam logic [6:0] MaxDay   = 7'd31;
   localparam logic [6:0] MaxMonth = 7'd12;

   typedef logic [3:0] nibble_type;
   typedef nibble_type [NumDigits-1:0] digits_type;
   typedef logic [CodeWidth-1:0] code_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

// ----- sv/date_token_extractor_top.sv -----
// Date token extractor. Scans one 8-bit character per transaction for tokens of the
// form dDDmMMyYYYY (lowercase d, m, y and ASCII digits) and returns one transaction
// with the date code YYYYMMDD for each complete token whose day is at most 31 and
// whose month is at most 12; other tokens return nothing. Matching restarts after
// each token with no overlap, a mismatch drops the partial match (a 'd' opens a new
// one), and end_of_text clears the match after its own character. The block takes
// one character every cycle while req_ready is high. A date code reaches the rsp_
// port through the digit check stage, the year/month/day stage and the output
// register, in that order. req_ready falls only when the check stage, the date
// stage and the output register all hold a transaction and rsp_ready is low.
module date_token_extractor_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_char_in,
   input  logic                req_end_of_text,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dte_pkg::code_type   rsp_date_code
);
   import dte_pkg::*;

   logic [3:0]    pos_ff;
   logic [3:0]    pos_in;
   logic          rsp_valid_ff;
   code_type      rsp_code_ff;

   logic          accept;
   logic [3:0]    pos_cur;
   logic          want_digit;
   logic [7:0]    want_char;
   logic          char_is_digit;
   logic          hit;
   logic          complete;
   cell_ctrl_type cell_ctrl;
   nibble_type    new_digit;
   nibble_type    cell_q [NumHeld];
   digits_type    token_digits;

   logic          cu_in_ready;
   logic          cu_out_valid;
   code_type      cu_code;
   logic          out_free;

   assign req_ready = cu_in_ready;
   assign accept    = req_valid && req_ready;

   // Classify the character against the token shape at the current position
   always_comb begin
      pos_cur = (pos_ff >= TokenLen) ? PosD : pos_ff;
      want_digit = 1'b0;
      want_char  = CharD;
      unique case (pos_cur)
         PosD:    want_char = CharD;
         PosM:    want_char = CharM;
         PosY:    want_char = CharY;
         default: want_digit = 1'b1;
      endcase
      char_is_digit = (req_char_in >= CharZero) && (req_char_in <= CharNine);
      hit           = want_digit ? char_is_digit : (req_char_in == want_char);
      complete      = hit && want_digit && (pos_cur == PosLast);
      new_digit     = req_char_in[3:0];
   end

   // Advance the match position; drop it on mismatch, token end or end of text
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (req_end_of_text || complete) begin
            pos_in = PosD;
         end else if (hit) begin
            pos_in = pos_cur + 4'd1;
         end else if (req_char_in == CharD) begin
            pos_in = PosD + 4'd1;
         end else begin
            pos_in = PosD;
         end
      end
   end

   // Clear wins over shift: the completing digit goes straight to the check stage
   assign cell_ctrl.shift = accept && hit && want_digit;
   assign cell_ctrl.clear = accept && (!hit || complete || req_end_of_text);

   // Row of digit cells: cell 0 takes the newest digit, each hands to its neighbor
   for (genvar k = 0; k < NumHeld; k++) begin : g_cell
      if (k == 0) begin : g_head
         dte_digit_cell u_cell (
            .clock    (clock),
            .ctrl     (cell_ctrl),
            .data_in  (new_digit),
            .data_out (cell_q[k])
         );
      end else begin : g_body
         dte_digit_cell u_cell (
            .clock    (clock),
            .ctrl     (cell_ctrl),
            .data_in  (cell_q[k-1]),
            .data_out (cell_q[k])
         );
      end
      // oldest cell holds the day tens digit
      assign token_digits[k] = cell_q[NumHeld-1-k];
   end
   assign token_digits[NumDigits-1] = new_digit;

   dte_code_unit u_code (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && complete),
      .in_ready  (cu_in_ready),
      .digits    (token_digits),
      .out_valid (cu_out_valid),
      .out_ready (out_free),
      .code      (cu_code)
   );

   // Output register: hold the transaction until the sink takes it
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= PosD;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         if (out_free) begin
            rsp_valid_ff <= cu_out_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && cu_out_valid) begin
         rsp_code_ff <= cu_code;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_date_code = rsp_code_ff;

endmodule

// ----- sv/dte_digit_cell.sv -----
module dte_digit_cell (
   input  logic                   clock,
   input  dte_pkg::cell_ctrl_type ctrl,
   input  dte_pkg::nibble_type    data_in,
   output dte_pkg::nibble_type    data_out
);
   import dte_pkg::*;

   nibble_type data_ff;
   nibble_type data_in_w;

   always_comb begin
      data_in_w = data_ff;
      if (ctrl.clear) begin
         data_in_w = '0;
      end else if (ctrl.shift) begin
         data_in_w = data_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in_w;
   end

   assign data_out = data_ff;

endmodule

// ----- sv/dte_code_unit.sv -----
module dte_code_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  dte_pkg::digits_type digits,
   output logic                out_valid,
   input  logic                out_ready,
   output dte_pkg::code_type   code
);
   import dte_pkg::*;

   logic       s1_valid_ff;
   digits_type digits_ff;
   logic       s2_valid_ff;
   logic [13:0] year_ff;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff;

   logic        s1_free;
   logic        s2_free;
   logic [6:0]  day_w;
   logic [6:0]  month_w;
   logic [13:0] year_w;
   logic        date_ok;

   assign s2_free  = !s2_valid_ff || out_ready;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign in_ready = s1_free;

   // digits_ff[0] is day tens, digits_ff[7] is year ones
   always_comb begin
      day_w   = 7'({3'b0, digits_ff[0]} * 7'd10) + {3'b0, digits_ff[1]};
      month_w = 7'({3'b0, digits_ff[2]} * 7'd10) + {3'b0, digits_ff[3]};
      year_w  = 14'({10'b0, digits_ff[4]} * 14'd1000)
              + 14'({10'b0, digits_ff[5]} * 14'd100)
              + 14'({10'b0, digits_ff[6]} * 14'd10)
              + {10'b0, digits_ff[7]};
      date_ok = (day_w <= MaxDay) && (month_w <= MaxMonth);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_free) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff && date_ok;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_free && in_valid) begin
         digits_ff <= digits;
      end
      if (s2_free && s1_valid_ff) begin
         year_ff  <= year_w;
         month_ff <= month_w[3:0];
         day_ff   <= day_w[4:0];
      end
   end

   // Widen each part to the full code width before scaling
   assign out_valid = s2_valid_ff;
   assign code = code_type'(year_ff) * code_type'(14'd10000)
               + code_type'(month_ff) * code_type'(7'd100)
               + code_type'(day_ff);

endmodule
